// ===== src/sc2chr_pkg.sv =====
// ----------------------------------------------------------------------------
// sc2chr_pkg: scan-code translator package
// Special character codes, the unshifted and shifted key tables, and the
// lookup function of the translator; its checker shares the special codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sc2chr_pkg;

  localparam int unsigned TabDepth = 136;

  // Key codes and masks.
  localparam logic [7:0] REL_PREFIX = 8'hF0;
  localparam logic [7:0] TOP_CODE   = 8'h87;
  localparam logic [7:0] CTRL_MASK  = 8'h1F;

  // Special character codes (bit 7 set).
  localparam logic [7:0] SP_VIEW  = 8'h80;
  localparam logic [7:0] SP_SHIFT = 8'hE0;
  localparam logic [7:0] SP_BREAK = 8'hE1;
  localparam logic [7:0] SP_CTRL  = 8'hE2;
  localparam logic [7:0] SP_LATIN = 8'hE3;
  localparam logic [7:0] SP_NONE  = 8'hFF;

  // Function keys occupy the class 0xC0..0xDF.
  localparam logic [2:0] FNKEY_CLASS = 3'b110;

  typedef logic [7:0] tab_t [TabDepth];

  localparam tab_t LOWER_TAB = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hC1,
    8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h09, 8'h60, 8'hC2,
    8'hFF, 8'hE2, 8'hE0, 8'hE0, 8'hE0, 8'h71, 8'h31, 8'hC3,
    8'hFF, 8'hE0, 8'h7A, 8'h73, 8'h61, 8'h77, 8'h32, 8'hC4,
    8'hFF, 8'h63, 8'h78, 8'h64, 8'h65, 8'h34, 8'h33, 8'hC5,
    8'hFF, 8'h20, 8'h76, 8'h66, 8'h74, 8'h72, 8'h35, 8'hC6,
    8'hFF, 8'h6E, 8'h62, 8'h68, 8'h67, 8'h79, 8'h36, 8'hC7,
    8'hFF, 8'h80, 8'h6D, 8'h6A, 8'h75, 8'h37, 8'h38, 8'hC8,
    8'hFF, 8'h2C, 8'h6B, 8'h69, 8'h6F, 8'h30, 8'h39, 8'hC9,
    8'hFF, 8'h2E, 8'h2F, 8'h6C, 8'h3B, 8'h70, 8'h2D, 8'hCA,
    8'hFF, 8'hFF, 8'h27, 8'hFF, 8'h5B, 8'h3D, 8'hCB, 8'h0D,
    8'hE3, 8'hE0, 8'h0A, 8'h5D, 8'h5C, 8'hFF, 8'hCC, 8'hE1,
    8'h80, 8'h80, 8'hE1, 8'hE0, 8'h7F, 8'hFF, 8'h08, 8'hFF,
    8'hFF, 8'h31, 8'h80, 8'h34, 8'h37, 8'h2C, 8'hFF, 8'hFF,
    8'h30, 8'h2E, 8'h32, 8'h35, 8'h36, 8'h38, 8'hA1, 8'hA2,
    8'hFF, 8'h0A, 8'h33, 8'hFF, 8'hA4, 8'h39, 8'hA3, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h2D, 8'hFF, 8'hFF, 8'hFF
  };

  localparam tab_t UPPER_TAB = '{
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hC1,
    8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h09, 8'h7E, 8'hC2,
    8'hFF, 8'hE2, 8'hE0, 8'hE0, 8'hE0, 8'h51, 8'h21, 8'hC3,
    8'hFF, 8'hE0, 8'h5A, 8'h53, 8'h41, 8'h57, 8'h40, 8'hC4,
    8'hFF, 8'h43, 8'h58, 8'h44, 8'h45, 8'h24, 8'h23, 8'hC5,
    8'hFF, 8'h20, 8'h56, 8'h46, 8'h54, 8'h52, 8'h25, 8'hC6,
    8'hFF, 8'h4E, 8'h42, 8'h48, 8'h47, 8'h59, 8'h5E, 8'hC7,
    8'hFF, 8'h80, 8'h4D, 8'h4A, 8'h55, 8'h26, 8'h2A, 8'hC8,
    8'hFF, 8'h3C, 8'h4B, 8'h49, 8'h4F, 8'h29, 8'h28, 8'hC9,
    8'hFF, 8'h3E, 8'h3F, 8'h4C, 8'h3A, 8'h50, 8'h5F, 8'hCA,
    8'hFF, 8'hFF, 8'h22, 8'hFF, 8'h7B, 8'h2B, 8'hCB, 8'h0D,
    8'hE3, 8'hE0, 8'h0A, 8'h7D, 8'h7C, 8'hFF, 8'hCC, 8'hE1,
    8'h80, 8'h80, 8'hE1, 8'hE0, 8'h7F, 8'hFF, 8'h08, 8'hFF,
    8'hFF, 8'h31, 8'h80, 8'h34, 8'h37, 8'h2C, 8'hFF, 8'hFF,
    8'h30, 8'h2E, 8'h32, 8'h35, 8'h36, 8'h38, 8'hA1, 8'hA2,
    8'hFF, 8'h0A, 8'h33, 8'hFF, 8'hA4, 8'h39, 8'hA3, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h2D, 8'hFF, 8'hFF, 8'hFF
  };

  // Table lookup; codes past the end of the table read as no mapping.
  function automatic logic [7:0] tab_lookup(input logic [7:0] code, input logic upper);
    logic [7:0] ch;
    if (code > TOP_CODE) begin
      ch = SP_NONE;
    end else if (upper) begin
      ch = UPPER_TAB[code];
    end else begin
      ch = LOWER_TAB[code];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== src/sc2chr_scan_if.sv =====
// ----------------------------------------------------------------------------
// sc2chr_scan_if: scan byte channel
// Valid/ready channel that carries one raw keyboard scan byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc2chr_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

`default_nettype wire

// ===== src/sc2chr_char_if.sv =====
// ----------------------------------------------------------------------------
// sc2chr_char_if: character channel
// Valid/ready channel that carries one translated character per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sc2chr_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== src/scancode_to_char_decoder.sv =====
// ----------------------------------------------------------------------------
// scancode_to_char_decoder: keyboard scan code to character translator
// Translates scan-code bytes through unshifted and shifted key tables and
// tracks the Shift, Ctrl and release-prefix state.
// ----------------------------------------------------------------------------
// Flow: a scan byte is accepted into the input register, and its character is
// then captured in the result register, which drives char_o.
// Throughput: one scan byte per cycle when not stalled; the table lookup and flag
// update for a byte are combinational between the two registers. A byte that
// gives a character waits while a stalled character holds the result register.
// Reset: rst_ni clears both valid bits and the Shift, Ctrl and release flags.
`default_nettype none

module scancode_to_char_decoder (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  sc2chr_scan_if.sink   scan_i,
  sc2chr_char_if.source char_o
);
  import sc2chr_pkg::*;

  // Input register: holds the byte being translated this cycle.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q,  s1_byte_d;

  // Keyboard state flags.
  logic rel_q,   rel_d;
  logic shift_q, shift_d;
  logic ctrl_q,  ctrl_d;

  // Result register.
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q,  out_char_d;

  // Translation of the byte in the input register.
  logic [7:0] tab_ch;
  logic       res_has;
  logic [7:0] res_char;
  logic       rel_n, shift_n, ctrl_n;

  logic out_free;
  logic s1_adv;
  logic in_take;

  // A released key is always looked up in the unshifted table, so the shifted
  // table is used only for a fresh press while Shift is down.
  assign tab_ch = tab_lookup(s1_byte_q, shift_q & ~rel_q);

  always_comb begin
    res_has  = 1'b0;
    res_char = tab_ch;
    rel_n    = rel_q;
    shift_n  = shift_q;
    ctrl_n   = ctrl_q;
    if (rel_q) begin
      // This byte names the released key. Only Shift and Ctrl matter, and a
      // code past the table reads as no mapping and so changes nothing.
      rel_n = 1'b0;
      if (tab_ch == SP_CTRL) begin
        ctrl_n = 1'b0;
      end else if (tab_ch == SP_SHIFT) begin
        shift_n = 1'b0;
      end
    end else if (s1_byte_q == REL_PREFIX) begin
      rel_n = 1'b1;
    end else if (s1_byte_q > TOP_CODE) begin
      // Codes above the table are dropped without a trace.
      res_has = 1'b0;
    end else if (!tab_ch[7]) begin
      // Plain character, masked to a control character while Ctrl is down.
      res_has  = 1'b1;
      res_char = ctrl_q ? (tab_ch & CTRL_MASK) : tab_ch;
    end else if (tab_ch[7:5] == FNKEY_CLASS) begin
      // Function keys give nothing.
      res_has = 1'b0;
    end else begin
      unique case (tab_ch) inside
        SP_SHIFT:           shift_n = 1'b1;
        SP_CTRL:            ctrl_n  = 1'b1;
        SP_BREAK, SP_LATIN: res_has = 1'b0;
        default:            res_has = 1'b1;
      endcase
    end
  end

  // The result register can take a new character when it is empty or its
  // current one leaves this cycle. A byte that gives no character never waits.
  assign out_free = ~out_valid_q | char_o.ready;
  assign s1_adv   = s1_valid_q & (~res_has | out_free);
  assign in_take  = scan_i.valid & scan_i.ready;

  assign scan_i.ready = ~s1_valid_q | s1_adv;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_byte_d   = s1_byte_q;
    rel_d       = rel_q;
    shift_d     = shift_q;
    ctrl_d      = ctrl_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;

    if (char_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      s1_valid_d = 1'b0;
      rel_d      = rel_n;
      shift_d    = shift_n;
      ctrl_d     = ctrl_n;
      if (res_has) begin
        out_valid_d = 1'b1;
        out_char_d  = res_char;
      end
    end
    if (in_take) begin
      s1_valid_d = 1'b1;
      s1_byte_d  = scan_i.scan_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rel_q       <= 1'b0;
      shift_q     <= 1'b0;
      ctrl_q      <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      rel_q       <= rel_d;
      shift_q     <= shift_d;
      ctrl_q      <= ctrl_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    s1_byte_q  <= s1_byte_d;
    out_char_q <= out_char_d;
  end

  assign char_o.valid     = out_valid_q;
  assign char_o.char_code = out_char_q;

endmodule

`default_nettype wire

// ===== src/sc2chr_checker.sv =====
// ----------------------------------------------------------------------------
// sc2chr_checker: port checker for the scan-code translator
// Watches the character channel for stall behavior and for special codes
// that the translator must never send out.
// ----------------------------------------------------------------------------
`default_nettype none

module sc2chr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_char_i
);
  import sc2chr_pkg::*;

  // A stalled character stays offered.
  property p_valid_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_ready_i |=> out_valid_i;
  endproperty
  a_valid_holds: assert property (p_valid_holds)
    else $error("character request dropped while stalled");

  // A stalled character keeps its value.
  property p_char_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_ready_i |=> $stable(out_char_i);
  endproperty
  a_char_holds: assert property (p_char_holds)
    else $error("character changed while stalled");

  // Function keys are swallowed.
  property p_no_fnkey;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_i |-> out_char_i[7:5] != FNKEY_CLASS;
  endproperty
  a_no_fnkey: assert property (p_no_fnkey)
    else $error("function key code sent out");

  // Shift and Ctrl only act on state, Break and Latin are dropped, and none appear.
  property p_no_modifier;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_i |-> !(out_char_i == SP_SHIFT || out_char_i == SP_CTRL ||
                        out_char_i == SP_BREAK || out_char_i == SP_LATIN);
  endproperty
  a_no_modifier: assert property (p_no_modifier)
    else $error("modifier code sent out");

endmodule

bind scancode_to_char_decoder sc2chr_checker u_sc2chr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (char_o.valid),
  .out_ready_i (char_o.ready),
  .out_char_i  (char_o.char_code)
);

`default_nettype wire
